// File: rtl/lrsi_pkg.sv
// Shared constants, types and helpers for the line/ray/segment intersection block.
package lrsi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int OUT_NUM_W  = 49;
  localparam int OUT_DEN_W  = 34;

  localparam int AW = COORD_BITS + 1;       // line coefficients A, B
  localparam int MW = 2 * COORD_BITS;       // coordinate products
  localparam int CW = 2 * COORD_BITS + 1;   // coefficient C
  localparam int PW = 2 * COORD_BITS + 2;   // A*B products
  localparam int DW = 2 * COORD_BITS + 3;   // determinant
  localparam int XW = 3 * COORD_BITS + 2;   // A*C, B*C products
  localparam int NW = 3 * COORD_BITS + 3;   // numerators, coordinate times determinant

  typedef enum logic [1:0] {
    KIND_LINE = 2'd0,
    KIND_RAY  = 2'd1,
    KIND_SEG  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OUT_NONE = 2'd0,
    OUT_ONE  = 2'd1,
    OUT_MANY = 2'd2
  } outcome_e;

  typedef struct packed {
    kind_e                  kind;
    logic [COORD_BITS-1:0]  x1;
    logic [COORD_BITS-1:0]  y1;
    logic [COORD_BITS-1:0]  x2;
    logic [COORD_BITS-1:0]  y2;
  } prim_t;

  typedef struct packed {
    outcome_e               outcome;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
  } colin_t;

  function automatic logic [COORD_BITS-1:0] sext(logic [FIELD_W-1:0] f);
    return COORD_BITS'(f);
  endfunction

  function automatic kind_e norm_kind(logic [1:0] k);
    kind_e r;
    case (k)
      KIND_RAY: r = KIND_RAY;
      KIND_SEG: r = KIND_SEG;
      default:  r = KIND_LINE;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/lrsi_colin.sv
// Endpoint-touch rules for a collinear pair of primitives.
module lrsi_colin (
  input  lrsi_pkg::prim_t  p_i,
  input  lrsi_pkg::prim_t  q_i,
  output lrsi_pkg::colin_t res_o
);
  import lrsi_pkg::*;

  logic                          vert;
  logic signed [COORD_BITS-1:0]  pe1, pe2, qe1, qe2;
  logic signed [COORD_BITS-1:0]  plo, phi, qlo, qhi;

  always_comb begin
    vert = (p_i.x1 == p_i.x2) && (q_i.x1 == q_i.x2);
    pe1  = $signed(vert ? p_i.y1 : p_i.x1);
    pe2  = $signed(vert ? p_i.y2 : p_i.x2);
    qe1  = $signed(vert ? q_i.y1 : q_i.x1);
    qe2  = $signed(vert ? q_i.y2 : q_i.x2);
    plo  = (pe1 < pe2) ? pe1 : pe2;
    phi  = (pe1 < pe2) ? pe2 : pe1;
    qlo  = (qe1 < qe2) ? qe1 : qe2;
    qhi  = (qe1 < qe2) ? qe2 : qe1;
  end

  always_comb begin
    res_o.outcome = OUT_MANY;
    res_o.x       = p_i.x1;
    res_o.y       = p_i.y1;
    if (p_i.kind == KIND_LINE || q_i.kind == KIND_LINE) begin
      res_o.outcome = OUT_MANY;
    end else if (p_i.kind == KIND_RAY && q_i.kind == KIND_RAY) begin
      // pe1/qe1 = end, pe2/qe2 = direction point
      if ((pe2 > pe1 && pe1 > qe1 && qe1 > qe2) ||
          (pe2 < pe1 && pe1 < qe1 && qe1 < qe2)) begin
        res_o.outcome = OUT_NONE;
      end else if ((pe2 > pe1 && pe1 == qe1 && qe1 > qe2) ||
                   (pe2 < pe1 && pe1 == qe1 && qe1 < qe2)) begin
        res_o.outcome = OUT_ONE;
      end
    end else if (p_i.kind == KIND_RAY) begin
      if ((pe2 > pe1 && pe1 > qhi) || (pe2 < pe1 && pe1 < qlo)) begin
        res_o.outcome = OUT_NONE;
      end else if ((pe2 > pe1 && pe1 == qhi) || (pe2 < pe1 && pe1 == qlo)) begin
        res_o.outcome = OUT_ONE;
      end
    end else if (q_i.kind == KIND_RAY) begin
      res_o.x = q_i.x1;
      res_o.y = q_i.y1;
      if ((qe2 > qe1 && qe1 > phi) || (qe2 < qe1 && qe1 < plo)) begin
        res_o.outcome = OUT_NONE;
      end else if ((qe2 > qe1 && qe1 == phi) || (qe2 < qe1 && qe1 == plo)) begin
        res_o.outcome = OUT_ONE;
      end
    end else begin
      if (plo > qhi || phi < qlo) begin
        res_o.outcome = OUT_NONE;
      end else if (plo == qhi) begin
        res_o.outcome = OUT_ONE;
        if (pe1 > pe2) begin
          res_o.x = p_i.x2;
          res_o.y = p_i.y2;
        end
      end else if (phi == qlo) begin
        res_o.outcome = OUT_ONE;
        if (pe1 < pe2) begin
          res_o.x = p_i.x2;
          res_o.y = p_i.y2;
        end
      end
    end
  end

endmodule

// File: rtl/line_ray_segment_intersect_top.sv
// Top level: seven-stage pipeline intersecting two lines, rays or segments.
// Throughput: one word per cycle while the output side takes words.
// The whole pipe advances together; a stall at the output freezes every stage.
// The input is ready whenever the output register is empty or being taken.
// Reset (rst_ni low, async) clears only the stage valid bits.
module line_ray_segment_intersect_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             kind_a_i,
  input  logic signed [lrsi_pkg::FIELD_W-1:0]    a_x1_i,
  input  logic signed [lrsi_pkg::FIELD_W-1:0]    a_y1_i,
  input  logic signed [lrsi_pkg::FIELD_W-1:0]    a_x2_i,
  input  logic signed [lrsi_pkg::FIELD_W-1:0]    a_y2_i,
  input  logic [1:0]                             kind_b_i,
  input  logic signed [lrsi_pkg::FIELD_W-1:0]    b_x1_i,
  input  logic signed [lrsi_pkg::FIELD_W-1:0]    b_y1_i,
  input  logic signed [lrsi_pkg::FIELD_W-1:0]    b_x2_i,
  input  logic signed [lrsi_pkg::FIELD_W-1:0]    b_y2_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [1:0]                             outcome_o,
  output logic signed [lrsi_pkg::OUT_NUM_W-1:0]  x_numerator_o,
  output logic signed [lrsi_pkg::OUT_NUM_W-1:0]  y_numerator_o,
  output logic [lrsi_pkg::OUT_DEN_W-1:0]         denominator_o
);
  import lrsi_pkg::*;

  // Global advance: every stage moves when the output register can move.
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  // primitives travel down the pipe through stage 6
  prim_t p1_q, q1_q, p2_q, q2_q, p3_q, q3_q, p4_q, q4_q, p5_q, q5_q, p6_q, q6_q;
  colin_t col_d, col2_q, col3_q, col4_q, col5_q, col6_q;

  // stage 2: A, B and the products for C
  logic signed [AW-1:0] pa2_q, pb2_q, qa2_q, qb2_q;
  logic signed [MW-1:0] pm1_q, pm2_q, qm1_q, qm2_q;
  // stage 3: C, determinant products
  logic signed [AW-1:0] pa3_q, pb3_q, qa3_q, qb3_q;
  logic signed [CW-1:0] pc3_q, qc3_q;
  logic signed [PW-1:0] dm1_q, dm2_q;
  // stage 4: determinant, numerator products
  logic signed [DW-1:0] den4_q;
  logic signed [XW-1:0] pbqc_q, qbpc_q, qapc_q, paqc_q;
  // stage 5: normalized numerators and determinant
  logic signed [NW-1:0] nx_d, ny_d, nx5_q, ny5_q, nx6_q, ny6_q;
  logic signed [DW-1:0] den_d, den5_q, den6_q;
  logic                 dz5_q, cok5_q, dz6_q, cok6_q;
  // stage 6: coordinates scaled by the determinant
  logic signed [NW-1:0] px1d_q, px2d_q, py1d_q, py2d_q;
  logic signed [NW-1:0] qx1d_q, qx2d_q, qy1d_q, qy2d_q;
  // stage 7: output register
  outcome_e                    outcome_d, outcome_q;
  logic signed [OUT_NUM_W-1:0] xn_d, yn_d, xn_q, yn_q;
  logic [OUT_DEN_W-1:0]        dn_d, dn_q;
  logic                        p_ok, q_ok;

  assign en         = !v7_q || out_ready_i;
  assign in_ready_o = en;

  lrsi_colin u_colin (
    .p_i  (p1_q),
    .q_i  (q1_q),
    .res_o(col_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q;
    end
  end

  // sign-normalize: determinant made positive, numerators follow
  always_comb begin
    nx_d  = NW'(pbqc_q) - NW'(qbpc_q);
    ny_d  = NW'(qapc_q) - NW'(paqc_q);
    den_d = den4_q;
    if (den4_q[DW-1]) begin
      nx_d  = -nx_d;
      ny_d  = -ny_d;
      den_d = -den4_q;
    end
  end

  function automatic logic on_prim(prim_t pr, logic signed [NW-1:0] xn,
                                   logic signed [NW-1:0] yn,
                                   logic signed [NW-1:0] x1d, logic signed [NW-1:0] x2d,
                                   logic signed [NW-1:0] y1d, logic signed [NW-1:0] y2d);
    logic gx1, lx1, gx2, lx2, gy1, ly1, gy2, ly2, r;
    gx1 = xn >= x1d; lx1 = xn <= x1d; gx2 = xn >= x2d; lx2 = xn <= x2d;
    gy1 = yn >= y1d; ly1 = yn <= y1d; gy2 = yn >= y2d; ly2 = yn <= y2d;
    case (pr.kind)
      KIND_RAY: r = ((($signed(pr.x2) >= $signed(pr.x1)) && gx1) ||
                     (($signed(pr.x2) <= $signed(pr.x1)) && lx1)) &&
                    ((($signed(pr.y2) >= $signed(pr.y1)) && gy1) ||
                     (($signed(pr.y2) <= $signed(pr.y1)) && ly1));
      KIND_SEG: r = (gx1 || gx2) && (lx1 || lx2) && (gy1 || gy2) && (ly1 || ly2);
      default:  r = 1'b1;
    endcase
    return r;
  endfunction

  always_comb begin
    p_ok      = on_prim(p6_q, nx6_q, ny6_q, px1d_q, px2d_q, py1d_q, py2d_q);
    q_ok      = on_prim(q6_q, nx6_q, ny6_q, qx1d_q, qx2d_q, qy1d_q, qy2d_q);
    outcome_d = OUT_NONE;
    xn_d      = '0;
    yn_d      = '0;
    dn_d      = OUT_DEN_W'(1);
    if (!dz6_q) begin
      if (p_ok && q_ok) begin
        outcome_d = OUT_ONE;
        xn_d      = OUT_NUM_W'(nx6_q);
        yn_d      = OUT_NUM_W'(ny6_q);
        dn_d      = OUT_DEN_W'($unsigned(den6_q));
      end
    end else if (cok6_q) begin
      // parallel and coincident: endpoint-touch rules
      outcome_d = col6_q.outcome;
      if (col6_q.outcome == OUT_ONE) begin
        xn_d = OUT_NUM_W'($signed(col6_q.x));
        yn_d = OUT_NUM_W'($signed(col6_q.y));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // S1: capture, sign-extend, fold unused kind into line
      p1_q <= '{norm_kind(kind_a_i), sext(a_x1_i), sext(a_y1_i), sext(a_x2_i), sext(a_y2_i)};
      q1_q <= '{norm_kind(kind_b_i), sext(b_x1_i), sext(b_y1_i), sext(b_x2_i), sext(b_y2_i)};
      // S2: A = y2 - y1, B = x1 - x2, products for C
      p2_q   <= p1_q; q2_q <= q1_q; col2_q <= col_d;
      pa2_q  <= AW'($signed(p1_q.y2)) - AW'($signed(p1_q.y1));
      pb2_q  <= AW'($signed(p1_q.x1)) - AW'($signed(p1_q.x2));
      qa2_q  <= AW'($signed(q1_q.y2)) - AW'($signed(q1_q.y1));
      qb2_q  <= AW'($signed(q1_q.x1)) - AW'($signed(q1_q.x2));
      pm1_q  <= $signed(p1_q.x2) * $signed(p1_q.y1);
      pm2_q  <= $signed(p1_q.x1) * $signed(p1_q.y2);
      qm1_q  <= $signed(q1_q.x2) * $signed(q1_q.y1);
      qm2_q  <= $signed(q1_q.x1) * $signed(q1_q.y2);
      // S3: C, determinant products
      p3_q   <= p2_q; q3_q <= q2_q; col3_q <= col2_q;
      pa3_q  <= pa2_q; pb3_q <= pb2_q; qa3_q <= qa2_q; qb3_q <= qb2_q;
      pc3_q  <= CW'(pm1_q) - CW'(pm2_q);
      qc3_q  <= CW'(qm1_q) - CW'(qm2_q);
      dm1_q  <= pa2_q * qb2_q;
      dm2_q  <= qa2_q * pb2_q;
      // S4: determinant, numerator products
      p4_q   <= p3_q; q4_q <= q3_q; col4_q <= col3_q;
      den4_q <= DW'(dm1_q) - DW'(dm2_q);
      pbqc_q <= pb3_q * qc3_q;
      qbpc_q <= qb3_q * pc3_q;
      qapc_q <= qa3_q * pc3_q;
      paqc_q <= pa3_q * qc3_q;
      // S5: numerators; coincidence needs both numerators zero
      p5_q   <= p4_q; q5_q <= q4_q; col5_q <= col4_q;
      nx5_q  <= nx_d; ny5_q <= ny_d; den5_q <= den_d;
      dz5_q  <= (den4_q == '0);
      cok5_q <= (nx_d == '0) && (ny_d == '0);
      // S6: bounds scaled by the determinant
      p6_q   <= p5_q; q6_q <= q5_q; col6_q <= col5_q;
      nx6_q  <= nx5_q; ny6_q <= ny5_q; den6_q <= den5_q;
      dz6_q  <= dz5_q; cok6_q <= cok5_q;
      px1d_q <= $signed(p5_q.x1) * den5_q;
      px2d_q <= $signed(p5_q.x2) * den5_q;
      py1d_q <= $signed(p5_q.y1) * den5_q;
      py2d_q <= $signed(p5_q.y2) * den5_q;
      qx1d_q <= $signed(q5_q.x1) * den5_q;
      qx2d_q <= $signed(q5_q.x2) * den5_q;
      qy1d_q <= $signed(q5_q.y1) * den5_q;
      qy2d_q <= $signed(q5_q.y2) * den5_q;
      // S7: output register
      outcome_q <= outcome_d;
      xn_q      <= xn_d;
      yn_q      <= yn_d;
      dn_q      <= dn_d;
    end
  end

  assign out_valid_o   = v7_q;
  assign outcome_o     = outcome_q;
  assign x_numerator_o = xn_q;
  assign y_numerator_o = yn_q;
  assign denominator_o = dn_q;

  a_no_point_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != OUT_ONE) |->
      (x_numerator_o == '0) && (y_numerator_o == '0) && (denominator_o == OUT_DEN_W'(1)))
    else $error("non-point outcome with nonzero point fields");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (denominator_o != '0))
    else $error("zero denominator");

  a_den_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> !den5_q[DW-1])
    else $error("determinant not normalized");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && !out_ready_i |=> v7_q && $stable(outcome_q) && $stable(dn_q))
    else $error("output word changed under stall");

endmodule

// File: tb/sv/tb.sv
// Testbench for the line/ray/segment intersection pipeline: directed table plus random words.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrsi_pkg::*;

  // One input word: two primitives.
  typedef struct {
    logic [1:0]         ka;
    logic signed [15:0] ax1, ay1, ax2, ay2;
    logic [1:0]         kb;
    logic signed [15:0] bx1, by1, bx2, by2;
  } pair_t;

  // One result word.
  typedef struct packed {
    outcome_e           oc;
    logic signed [48:0] xn;
    logic signed [48:0] yn;
    logic [33:0]        den;
  } hit_t;

  // Directed row: stimulus plus an optional hand-typed result.
  typedef struct {
    pair_t p;
    bit    typed;
    hit_t  r;
  } row_t;

  // Working form of one primitive, widened to 64 bits.
  typedef struct {
    kind_e       k;
    longint      x1, y1, x2, y2, a, b, c;
  } geo_t;

  localparam int LIMIT_CYCLES = 400000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0] kind_a_i, kind_b_i, outcome_o;
  logic signed [15:0] a_x1_i, a_y1_i, a_x2_i, a_y2_i, b_x1_i, b_y1_i, b_x2_i, b_y2_i;
  logic signed [48:0] x_numerator_o, y_numerator_o;
  logic [33:0] denominator_o;

  hit_t   pending_hits[$];
  int     errors;
  longint cycles;

  line_ray_segment_intersect_top u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Global watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic geo_t make_geo(logic [1:0] k, logic signed [15:0] x1, y1, x2, y2);
    geo_t g;
    g.k  = (k == KIND_RAY) ? KIND_RAY : (k == KIND_SEG) ? KIND_SEG : KIND_LINE;
    g.x1 = x1; g.y1 = y1; g.x2 = x2; g.y2 = y2;
    g.a  = g.y2 - g.y1;
    g.b  = g.x1 - g.x2;
    g.c  = g.x2 * g.y1 - g.x1 * g.y2;
    return g;
  endfunction

  function automatic bit same_side(longint u, longint v);
    return (u >= 0 && v >= 0) || (u <= 0 && v <= 0);
  endfunction

  // Does (xn/d, yn/d) lie on the primitive? d > 0.
  function automatic bit point_fits(geo_t g, longint xn, longint yn, longint d);
    longint xl, xh, yl, yh;
    xl = (g.x1 < g.x2) ? g.x1 : g.x2;
    xh = (g.x1 < g.x2) ? g.x2 : g.x1;
    yl = (g.y1 < g.y2) ? g.y1 : g.y2;
    yh = (g.y1 < g.y2) ? g.y2 : g.y1;
    case (g.k)
      KIND_RAY: return same_side(g.x2 - g.x1, xn - g.x1 * d) &&
                       same_side(g.y2 - g.y1, yn - g.y1 * d);
      KIND_SEG: return xn >= xl * d && xn <= xh * d && yn >= yl * d && yn <= yh * d;
      default:  return 1'b1;
    endcase
  endfunction

  // Overlap rules for two primitives on one line.
  function automatic outcome_e overlap(geo_t p, geo_t q, output longint px, output longint py);
    bit vert;
    longint e1, c1, e2, c2, lo, hi, lo1, hi1, lo2, hi2;
    vert = (p.b == 0 && q.b == 0);
    px = 0; py = 0;
    if (p.k == KIND_LINE || q.k == KIND_LINE) return OUT_MANY;
    if (p.k == KIND_SEG && q.k == KIND_RAY) return overlap(q, p, px, py);
    e1 = vert ? p.y1 : p.x1; c1 = vert ? p.y2 : p.x2;
    e2 = vert ? q.y1 : q.x1; c2 = vert ? q.y2 : q.x2;
    if (p.k == KIND_RAY && q.k == KIND_RAY) begin
      if ((c1 > e1 && e1 > e2 && e2 > c2) || (c1 < e1 && e1 < e2 && e2 < c2))
        return OUT_NONE;
      if ((c1 > e1 && e1 == e2 && e2 > c2) || (c1 < e1 && e1 == e2 && e2 < c2)) begin
        px = p.x1; py = p.y1;
        return OUT_ONE;
      end
      return OUT_MANY;
    end
    if (p.k == KIND_RAY) begin
      lo = (e2 < c2) ? e2 : c2;
      hi = (e2 < c2) ? c2 : e2;
      if ((c1 > e1 && e1 > hi) || (c1 < e1 && e1 < lo)) return OUT_NONE;
      if ((c1 > e1 && e1 == hi) || (c1 < e1 && e1 == lo)) begin
        px = p.x1; py = p.y1;
        return OUT_ONE;
      end
      return OUT_MANY;
    end
    lo1 = (e1 < c1) ? e1 : c1; hi1 = (e1 < c1) ? c1 : e1;
    lo2 = (e2 < c2) ? e2 : c2; hi2 = (e2 < c2) ? c2 : e2;
    if (lo1 > hi2 || hi1 < lo2) return OUT_NONE;
    if (lo1 == hi2) begin
      if (e1 > c1) begin px = p.x2; py = p.y2; end
      else begin px = p.x1; py = p.y1; end
      return OUT_ONE;
    end
    if (hi1 == lo2) begin
      if (e1 < c1) begin px = p.x2; py = p.y2; end
      else begin px = p.x1; py = p.y1; end
      return OUT_ONE;
    end
    return OUT_MANY;
  endfunction

  function automatic hit_t predict_hit(pair_t w);
    geo_t p, q;
    hit_t h;
    longint den, nx, ny, ex, ey;
    p = make_geo(w.ka, w.ax1, w.ay1, w.ax2, w.ay2);
    q = make_geo(w.kb, w.bx1, w.by1, w.bx2, w.by2);
    h.oc = OUT_NONE; h.xn = '0; h.yn = '0; h.den = 34'd1;
    den = p.a * q.b - q.a * p.b;
    nx  = p.b * q.c - q.b * p.c;
    ny  = q.a * p.c - p.a * q.c;
    if (den != 0) begin
      if (den < 0) begin den = -den; nx = -nx; ny = -ny; end
      if (point_fits(p, nx, ny, den) && point_fits(q, nx, ny, den)) begin
        h.oc = OUT_ONE; h.xn = nx[48:0]; h.yn = ny[48:0]; h.den = den[33:0];
      end
    end else if (nx == 0 && p.a * q.c - q.a * p.c == 0) begin
      h.oc = overlap(p, q, ex, ey);
      if (h.oc == OUT_ONE) begin h.xn = ex[48:0]; h.yn = ey[48:0]; end
    end
    return h;
  endfunction

  function automatic pair_t mk(logic [1:0] ka, int ax1, ay1, ax2, ay2,
                               logic [1:0] kb, int bx1, by1, bx2, by2);
    pair_t w;
    w.ka = ka; w.ax1 = 16'(ax1); w.ay1 = 16'(ay1); w.ax2 = 16'(ax2); w.ay2 = 16'(ay2);
    w.kb = kb; w.bx1 = 16'(bx1); w.by1 = 16'(by1); w.bx2 = 16'(bx2); w.by2 = 16'(by2);
    return w;
  endfunction

  function automatic hit_t res(outcome_e oc, longint xn, longint yn, longint d);
    hit_t h;
    h.oc = oc; h.xn = xn[48:0]; h.yn = yn[48:0]; h.den = d[33:0];
    return h;
  endfunction

  // Random coordinate: mostly a small grid so crossings and touches happen.
  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return 16'($urandom());
      default: return $signed(16'($urandom_range(0, 12))) - 16'sd6;
    endcase
  endfunction

  function automatic pair_t rnd_pair();
    pair_t w;
    int mode;
    int dx, dy, t0, t1, t2, t3;
    w.ka = 2'($urandom_range(0, 3)); w.kb = 2'($urandom_range(0, 3));
    w.ax1 = rnd_coord(); w.ay1 = rnd_coord(); w.ax2 = rnd_coord(); w.ay2 = rnd_coord();
    w.bx1 = rnd_coord(); w.by1 = rnd_coord(); w.bx2 = rnd_coord(); w.by2 = rnd_coord();
    mode = $urandom_range(0, 3);
    if (mode == 0) begin
      // Both on one line through (ax1, ay1) with a small direction.
      dx = $urandom_range(0, 4) - 2; dy = $urandom_range(0, 4) - 2;
      t0 = $urandom_range(0, 6) - 3; t1 = $urandom_range(0, 6) - 3;
      t2 = $urandom_range(0, 6) - 3; t3 = $urandom_range(0, 6) - 3;
      w.ax1 = $signed(16'($urandom_range(0, 20))) - 16'sd10;
      w.ay1 = $signed(16'($urandom_range(0, 20))) - 16'sd10;
      w.ax2 = w.ax1 + 16'(t0 * dx); w.ay2 = w.ay1 + 16'(t0 * dy);
      w.ax1 = w.ax1 + 16'(t3 * dx); w.ay1 = w.ay1 + 16'(t3 * dy);
      w.bx1 = w.ax2 + 16'(t1 * dx); w.by1 = w.ay2 + 16'(t1 * dy);
      w.bx2 = w.ax2 + 16'(t2 * dx); w.by2 = w.ay2 + 16'(t2 * dy);
    end else if (mode == 1) begin
      // Parallel copy, offset.
      w.bx1 = w.ax1 + 16'sd3; w.by1 = w.ay1 - 16'sd1;
      w.bx2 = w.ax2 + 16'sd3; w.by2 = w.ay2 - 16'sd1;
    end
    return w;
  endfunction

  row_t dir_rows[$];

  function automatic void add_row(pair_t p, bit typed, hit_t r);
    row_t rw;
    rw.p = p; rw.typed = typed; rw.r = r;
    dir_rows.insert(dir_rows.size(), rw);
  endfunction

  initial begin
    int burst, gap;
    pair_t w;
    hit_t ph;
    in_valid_i = 1'b0;
    {kind_a_i, a_x1_i, a_y1_i, a_x2_i, a_y2_i} = '0;
    {kind_b_i, b_x1_i, b_y1_i, b_x2_i, b_y2_i} = '0;
    errors = 0; cycles = 0;
    rst_ni = 1'b0;

    // Directed table.
    add_row(mk(KIND_LINE, 0, 0, 2, 2, KIND_LINE, 0, 2, 2, 0), 1, res(OUT_ONE, 8, 8, 8));
    add_row(mk(KIND_LINE, 0, 0, 1, 0, KIND_LINE, 0, 1, 1, 1), 1, res(OUT_NONE, 0, 0, 1));
    add_row(mk(KIND_LINE, 0, 0, 1, 1, KIND_SEG, 2, 2, 5, 5), 1, res(OUT_MANY, 0, 0, 1));
    add_row(mk(KIND_RAY, 0, 0, 1, 0, KIND_RAY, -1, 0, -2, 0), 1, res(OUT_NONE, 0, 0, 1));
    add_row(mk(KIND_RAY, 0, 0, 1, 0, KIND_RAY, 0, 0, -2, 0), 1, res(OUT_ONE, 0, 0, 1));
    add_row(mk(KIND_RAY, 0, 0, 1, 0, KIND_RAY, 3, 0, 0, 0), 1, res(OUT_MANY, 0, 0, 1));
    add_row(mk(KIND_RAY, 5, 0, 6, 0, KIND_SEG, 1, 0, 3, 0), 1, res(OUT_NONE, 0, 0, 1));
    add_row(mk(KIND_SEG, 1, 0, 3, 0, KIND_RAY, 3, 0, 6, 0), 1, res(OUT_ONE, 3, 0, 1));
    add_row(mk(KIND_SEG, 0, 0, 2, 0, KIND_SEG, 3, 0, 5, 0), 1, res(OUT_NONE, 0, 0, 1));
    add_row(mk(KIND_SEG, 4, 0, 2, 0, KIND_SEG, 0, 0, 2, 0), 1, res(OUT_ONE, 2, 0, 1));
    add_row(mk(KIND_SEG, 0, 0, 2, 0, KIND_SEG, 2, 0, 5, 0), 1, res(OUT_ONE, 2, 0, 1));
    add_row(mk(KIND_SEG, 0, 1, 0, 5, KIND_SEG, 0, 5, 0, 9), 1, res(OUT_ONE, 0, 5, 1));
    add_row(mk(KIND_SEG, 0, 0, 4, 0, KIND_SEG, 1, 0, 2, 0), 1, res(OUT_MANY, 0, 0, 1));
    // Degenerate points and the unused kind code.
    add_row(mk(KIND_SEG, 2, 2, 2, 2, KIND_SEG, 2, 2, 2, 2), 0, res(OUT_NONE, 0, 0, 1));
    add_row(mk(KIND_RAY, 1, 1, 1, 1, KIND_SEG, 0, 0, 4, 4), 0, res(OUT_NONE, 0, 0, 1));
    add_row(mk(2'd3, 0, 0, 1, 1, KIND_RAY, 0, 0, -1, -1), 1, res(OUT_MANY, 0, 0, 1));
    add_row(mk(2'd3, 0, 0, 2, 2, KIND_SEG, 0, 2, 2, 0), 0, res(OUT_NONE, 0, 0, 1));
    // Field extremes.
    add_row(mk(KIND_LINE, -32768, -32768, 32767, 32767,
               KIND_LINE, -32768, 32767, 32767, -32768), 0, res(OUT_NONE, 0, 0, 1));
    add_row(mk(KIND_SEG, -32768, 32767, 32767, -32768,
               KIND_RAY, 32767, 32767, -32768, -32767), 0, res(OUT_NONE, 0, 0, 1));
    add_row(mk(KIND_RAY, 32767, -32768, -32768, 32767,
               KIND_SEG, -1, -1, 0, 0), 0, res(OUT_NONE, 0, 0, 1));
    add_row(mk(KIND_RAY, 0, 0, 1, 1, KIND_SEG, -3, 3, -1, 1), 1, res(OUT_NONE, 0, 0, 1));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Sender: directed rows, then random words, in bursts with gaps.
    for (int i = 0; i < dir_rows.size() + 1600; i++) begin
      if (i < dir_rows.size()) begin
        w = dir_rows[i].p;
        if (dir_rows[i].typed) begin
          // hand value must agree with the predictor, and drives the check
          ph = predict_hit(w);
          if (ph != dir_rows[i].r) begin
            $display("%0t directed row %0d: typed exp %0d/%0d/%0d/%0d predictor %0d/%0d/%0d/%0d",
                     $time, i, dir_rows[i].r.oc, dir_rows[i].r.xn, dir_rows[i].r.yn,
                     dir_rows[i].r.den, ph.oc, ph.xn, ph.yn, ph.den);
            errors++;
          end
        end
      end else begin
        w = rnd_pair();
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst--;
      in_valid_i = 1'b1;
      kind_a_i = w.ka; a_x1_i = w.ax1; a_y1_i = w.ay1; a_x2_i = w.ax2; a_y2_i = w.ay2;
      kind_b_i = w.kb; b_x1_i = w.bx1; b_y1_i = w.by1; b_x2_i = w.bx2; b_y2_i = w.by2;
      // wait at rising edges until in_ready_o is seen high
      do @(posedge clk_i); while (!in_ready_o);
      pending_hits.insert(pending_hits.size(), (i < dir_rows.size() && dir_rows[i].typed) ?
                          dir_rows[i].r : predict_hit(w));
      @(negedge clk_i);
    end
    in_valid_i = 1'b0;

    wait (pending_hits.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off to fill the pipe.
  initial begin
    int phase;
    out_ready_i = 1'b0;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      phase++;
      if (phase == 300) begin
        out_ready_i = 1'b0;
        repeat (60) @(negedge clk_i);
      end
      if ((phase / 150) % 3 == 1) out_ready_i = 1'b1;   // stretch with no stalls
      else out_ready_i = ($urandom_range(0, 3) != 0);
    end
  end

  // Checker: compare each taken word with the oldest expectation.
  always @(posedge clk_i) begin
    hit_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hits.size() == 0) begin
        $display("%0t unexpected result word: exp none got outcome %0d", $time, outcome_o);
        errors++;
      end else begin
        e = pending_hits.pop_front();
        if (outcome_o != e.oc) begin
          $display("%0t outcome exp %0d got %0d", $time, e.oc, outcome_o);
          errors++;
        end
        if (x_numerator_o != e.xn) begin
          $display("%0t x_numerator exp %0d got %0d", $time, e.xn, x_numerator_o);
          errors++;
        end
        if (y_numerator_o != e.yn) begin
          $display("%0t y_numerator exp %0d got %0d", $time, e.yn, y_numerator_o);
          errors++;
        end
        if (denominator_o != e.den) begin
          $display("%0t denominator exp %0d got %0d", $time, e.den, denominator_o);
          errors++;
        end
      end
    end
  end

endmodule
